// ===== src/prfc_pkg.sv =====
// Package: shared constants, types and command/status structs for the fault counter.
`timescale 1ns / 1ps
`default_nettype none
package prfc_pkg;
	localparam int MaxRefs = 64;
	localparam int Frames = 3;
	localparam int AddrW = $clog2(MaxRefs);
	localparam int CntW = $clog2(MaxRefs + 1);
	localparam int PageW = 16;
	localparam int OutW = 7;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_LRU = 2'd1;
	localparam logic [1:0] POL_OPT = 2'd2;

	// Controller commands to the datapath.
	typedef struct packed {
		logic store;     // write incoming page into the store
		logic clr_run;   // clear frames and fault count, start replay
		logic rd_cur;    // issue read of current reference
		logic apply;     // apply current reference (hit/miss/fill) using current data
		logic scan_init; // begin lookahead scan for optimal eviction
		logic scan_rd;   // issue read of scan entry
		logic scan_cmp;  // compare scan data against frames
		logic evict_opt; // replace optimal victim
		logic next_ref;  // advance to next reference
		logic clr_str;   // clear string state after result
	} prfc_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic run_done;  // all stored references replayed
		logic need_opt;  // current reference misses with full frames under optimal
		logic scan_done; // lookahead scan ended
	} prfc_sts_t;
endpackage
`default_nettype wire

// ===== src/prfc_if.sv =====
// Interfaces: valid/ready channels for input items, result items and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface prfc_in_if;
	logic valid;
	logic ready;
	logic [15:0] page;
	logic last;
	modport source (output valid, page, last, input ready);
	modport sink (input valid, page, last, output ready);
endinterface

interface prfc_out_if;
	logic valid;
	logic ready;
	logic [6:0] fault_count;
	logic [6:0] ref_total;
	logic overflow;
	modport source (output valid, fault_count, ref_total, overflow, input ready);
	modport sink (input valid, fault_count, ref_total, overflow, output ready);
endinterface

interface prfc_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/prfc_datapath.sv =====
// Datapath: reference store, frames, ranks, counters and optimal lookahead scan.
`timescale 1ns / 1ps
`default_nettype none
module prfc_datapath import prfc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire prfc_cmd_t cmd,
	input wire logic [PageW-1:0] in_page,
	input wire logic [1:0] policy,
	output prfc_sts_t sts,
	output logic [OutW-1:0] fault_count,
	output logic [OutW-1:0] ref_total,
	output logic overflow
);
	logic [PageW-1:0] mem [MaxRefs];
	logic [PageW-1:0] rd_data_q;
	logic [CntW-1:0] ref_count_q;
	logic overflow_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] scan_q;
	logic [PageW-1:0] cur_q;
	logic [PageW-1:0] frame_page_q [Frames];
	logic [Frames-1:0] frame_valid_q;
	logic [1:0] frame_rank_q [Frames];
	logic [Frames-1:0] seen_q;
	logic [1:0] last_seen_q;
	logic [CntW-1:0] fault_q;
	logic [AddrW-1:0] rd_addr;

	logic [Frames-1:0] hit_vec;
	logic is_hit;
	logic [1:0] hit_idx, fill_idx, rank_victim, opt_victim, victim;
	logic full;

	// Hit and victim selection
	always_comb begin
		hit_vec = '0;
		for (int f = 0; f < Frames; f++)
			hit_vec[f] = frame_valid_q[f] && (frame_page_q[f] == rd_data_q);
		is_hit = |hit_vec;
		hit_idx = hit_vec[0] ? 2'd0 : (hit_vec[1] ? 2'd1 : 2'd2);
		full = &frame_valid_q;
		fill_idx = !frame_valid_q[0] ? 2'd0 : (!frame_valid_q[1] ? 2'd1 : 2'd2);
		rank_victim = 2'd0;
		for (int f = 1; f < Frames; f++)
			if (frame_rank_q[f] > frame_rank_q[rank_victim]) rank_victim = 2'(f);
		// Farthest: lowest frame never seen, else the last one found
		if (!seen_q[0]) opt_victim = 2'd0;
		else if (!seen_q[1]) opt_victim = 2'd1;
		else if (!seen_q[2]) opt_victim = 2'd2;
		else opt_victim = last_seen_q;
		victim = cmd.evict_opt ? opt_victim : (full ? rank_victim : fill_idx);
	end

	assign sts.run_done = (idx_q >= ref_count_q);
	assign sts.need_opt = !is_hit && full && (policy == POL_OPT);
	assign sts.scan_done = (scan_q >= ref_count_q) || (&seen_q);
	assign rd_addr = cmd.scan_rd ? scan_q[AddrW-1:0] : idx_q[AddrW-1:0];

	// Store writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.store && ref_count_q < CntW'(MaxRefs))
			mem[ref_count_q[AddrW-1:0]] <= in_page;
		if (cmd.rd_cur || cmd.scan_rd)
			rd_data_q <= mem[rd_addr];
	end

	// Control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= '0;
			overflow_q <= 1'b0;
			idx_q <= '0;
			scan_q <= '0;
			cur_q <= '0;
			fault_q <= '0;
			frame_valid_q <= '0;
			seen_q <= '0;
			last_seen_q <= '0;
			for (int f = 0; f < Frames; f++) begin
				frame_rank_q[f] <= '0;
				frame_page_q[f] <= '0;
			end
		end else begin
			if (cmd.store) begin
				if (ref_count_q < CntW'(MaxRefs)) ref_count_q <= ref_count_q + 1'b1;
				else overflow_q <= 1'b1;
			end
			if (cmd.clr_run) begin
				idx_q <= '0;
				fault_q <= '0;
				frame_valid_q <= '0;
			end
			if (cmd.next_ref) idx_q <= idx_q + 1'b1;
			// Hold current page for the scan
			if (cmd.scan_init) begin
				cur_q <= rd_data_q;
				scan_q <= idx_q + 1'b1;
				seen_q <= '0;
			end
			if (cmd.scan_rd) scan_q <= scan_q + 1'b1;
			if (cmd.scan_cmp) begin
				for (int f = 0; f < Frames; f++)
					if (!seen_q[f] && frame_page_q[f] == rd_data_q) begin
						seen_q[f] <= 1'b1;
						last_seen_q <= 2'(f);
					end
			end
			// Apply a reference: hit promotes under LRU, miss loads victim
			if (cmd.apply && is_hit) begin
				if (policy == POL_LRU)
					for (int f = 0; f < Frames; f++)
						if (2'(f) == hit_idx) frame_rank_q[f] <= '0;
						else if (frame_valid_q[f] && frame_rank_q[f] < frame_rank_q[hit_idx])
							frame_rank_q[f] <= frame_rank_q[f] + 1'b1;
			end else if ((cmd.apply && !sts.need_opt) || cmd.evict_opt) begin
				fault_q <= fault_q + 1'b1;
				for (int f = 0; f < Frames; f++)
					if (2'(f) == victim) begin
						frame_page_q[f] <= cmd.evict_opt ? cur_q : rd_data_q;
						frame_valid_q[f] <= 1'b1;
						frame_rank_q[f] <= '0;
					end else if (frame_valid_q[f]) begin
						frame_rank_q[f] <= frame_rank_q[f] + 1'b1;
					end
			end
			// Drop the string once its result is taken
			if (cmd.clr_str) begin
				ref_count_q <= '0;
				overflow_q <= 1'b0;
				fault_q <= '0;
			end
		end
	end

	assign fault_count = OutW'(fault_q);
	assign ref_total = OutW'(ref_count_q);
	assign overflow = overflow_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ref_count_q <= CntW'(MaxRefs)) else $error("ref count past capacity");
	a_fault_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q <= ref_count_q) else $error("faults exceed references");
	a_opt_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict_opt |-> full) else $error("optimal eviction with empty frame");
endmodule
`default_nettype wire

// ===== src/prfc_ctrl.sv =====
// Controller: state machine that sequences loading, replay, scan and result.
`timescale 1ns / 1ps
`default_nettype none
module prfc_ctrl import prfc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_last,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire prfc_sts_t sts,
	output prfc_cmd_t cmd
);
	typedef enum logic [7:0] {
		S_LOAD = 8'b0000_0001,
		S_START = 8'b0000_0010,
		S_READ = 8'b0000_0100,
		S_APPLY = 8'b0000_1000,
		S_SREAD = 8'b0001_0000,
		S_SCMP = 8'b0010_0000,
		S_EVICT = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_LOAD);
	assign out_valid = (state_q == S_DONE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.store = 1'b1;
					if (in_last) state_d = S_START;
				end
			end
			S_START: begin
				cmd.clr_run = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				if (sts.run_done) state_d = S_DONE;
				else begin
					cmd.rd_cur = 1'b1;
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				if (sts.need_opt) begin
					cmd.scan_init = 1'b1;
					state_d = S_SREAD;
				end else begin
					cmd.next_ref = 1'b1;
					state_d = S_READ;
				end
			end
			S_SREAD: begin
				if (sts.scan_done) state_d = S_EVICT;
				else begin
					cmd.scan_rd = 1'b1;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				cmd.scan_cmp = 1'b1;
				state_d = S_SREAD;
			end
			S_EVICT: begin
				cmd.evict_opt = 1'b1;
				cmd.next_ref = 1'b1;
				state_d = S_READ;
			end
			S_DONE: begin
				if (out_ready) begin
					cmd.clr_str = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else state_q <= state_d;
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("load and result overlap");
	a_evict_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict_opt |=> state_q == S_READ) else $error("eviction did not return");
endmodule
`default_nettype wire

// ===== src/page_replacement_fault_counter.sv =====
// Top level: page reference fault counter for FIFO, LRU and optimal replacement.
`timescale 1ns / 1ps
`default_nettype none
// Stores up to 64 page references, one item per cycle while loading; excess
// references are dropped and flagged. After the item marked last, a setup state
// clears the frames and the string is replayed over three frames: a reference
// takes a store read and an apply step; an optimal-policy eviction adds a scan
// that reads and compares later entries until every frame's next use is found
// or the string ends, then loads the frame. A final read step ends the replay.
// The result waits in an output register; loading resumes when it is taken.
// Policy must be written only while idle; the block itself does not enforce it.
module page_replacement_fault_counter import prfc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	prfc_in_if.sink in_ch,
	prfc_out_if.source out_ch,
	prfc_cfg_if.sink cfg
);
	prfc_cmd_t cmd;
	prfc_sts_t sts;
	logic [1:0] policy_q;

	// Hold policy register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) policy_q <= POL_FIFO;
		else if (cfg.valid) policy_q <= cfg.data;
	end

	prfc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_last(in_ch.last), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	prfc_datapath u_dp (
		.clk, .arst_n, .cmd,
		.in_page(in_ch.page), .policy(policy_q), .sts,
		.fault_count(out_ch.fault_count), .ref_total(out_ch.ref_total),
		.overflow(out_ch.overflow)
	);
endmodule
`default_nettype wire

// ===== test/tb_page_replacement_fault_counter.sv =====
// Testbench: checks page fault counts for FIFO, LRU and optimal replay of reference strings.
`timescale 1ns / 1ps
module tb_page_replacement_fault_counter;
	import prfc_pkg::*;

	typedef struct {
		logic [15:0] page;
		logic last;
	} ref_item_t;

	typedef struct {
		logic [6:0] fault_count;
		logic [6:0] ref_total;
		logic overflow;
	} fault_res_t;

	typedef struct {
		logic [15:0] page;
		logic last;
		bit typed;
		logic [6:0] fault_count;
		logic [6:0] ref_total;
		logic overflow;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prfc_in_if in_ch();
	prfc_out_if out_ch();
	prfc_cfg_if cfg();

	page_replacement_fault_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	always #1 clk = ~clk;

	// Predictor state
	logic [15:0] str_store [MaxRefs];
	int str_len;
	bit str_dropped;
	logic [1:0] cur_policy;

	fault_res_t pending_q[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int sink_wait = 0;
	bit hold_sink = 1'b0;
	bit long_hold = 1'b0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	function automatic int next_ref_at(input logic [15:0] pg, input int from);
		for (int k = from; k < str_len; k++)
			if (str_store[k] == pg) return k;
		return MaxRefs + 1;
	endfunction

	// Replay the stored string under the current policy and count faults.
	function automatic int count_faults();
		logic [15:0] fpage [3];
		bit fvalid [3];
		int frank [3];
		int faults;
		int hit;
		int victim;
		int best;
		int d;
		bit fresh;
		faults = 0;
		for (int f = 0; f < 3; f++) begin
			fpage[f] = '0; fvalid[f] = 0; frank[f] = 0;
		end
		for (int i = 0; i < str_len; i++) begin
			hit = 3;
			for (int f = 0; f < 3; f++)
				if (hit == 3 && fvalid[f] && fpage[f] == str_store[i]) hit = f;
			if (hit < 3) begin
				if (cur_policy == POL_LRU) begin
					for (int k = 0; k < 3; k++)
						if (k != hit && fvalid[k] && frank[k] < frank[hit]) frank[k]++;
					frank[hit] = 0;
				end
				continue;
			end
			faults++;
			victim = 3;
			for (int f = 0; f < 3; f++)
				if (victim == 3 && !fvalid[f]) victim = f;
			if (victim == 3) begin
				victim = 0;
				if (cur_policy == POL_OPT) begin
					best = 0;
					for (int f = 0; f < 3; f++) begin
						d = next_ref_at(fpage[f], i + 1);
						if (f == 0 || d > best) begin
							best = d; victim = f;
						end
					end
				end else begin
					for (int f = 1; f < 3; f++)
						if (frank[f] > frank[victim]) victim = f;
				end
				fvalid[victim] = 0;
			end
			fpage[victim] = str_store[i];
			fvalid[victim] = 1;
			for (int k = 0; k < 3; k++)
				if (k != victim && fvalid[k]) frank[k]++;
			frank[victim] = 0;
		end
		return faults;
	endfunction

	// Advance the predictor by one accepted item.
	task automatic predict_item(input ref_item_t it);
		fault_res_t r;
		int fc;
		if (str_len < MaxRefs) begin
			str_store[str_len] = it.page;
			str_len++;
		end else begin
			str_dropped = 1;
		end
		if (it.last) begin
			fc = count_faults();
			r.fault_count = fc > 127 ? 7'd127 : fc[6:0];
			r.ref_total = str_len > 127 ? 7'd127 : str_len[6:0];
			r.overflow = str_dropped;
			pending_q.push_back(r);
			str_len = 0;
			str_dropped = 0;
		end
	endtask

	// Sender: one item per handshake; valid drops only when a gap follows
	int send_gap_max = 18;

	task automatic send_item(input ref_item_t it);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.page <= it.page;
		in_ch.last <= it.last;
		do @(posedge clk); while (!in_ch.ready);
		predict_item(it);
		items_sent++;
	endtask

	task automatic write_policy(input logic [1:0] p);
		cfg.valid <= 1'b1;
		cfg.data <= p;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_policy = p;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_string(input int len, input int span, input bit tail);
		ref_item_t it;
		for (int k = 0; k < len; k++) begin
			it.page = span == 0 ? 16'($urandom) : 16'($urandom_range(0, span));
			if ($urandom_range(0, 9) == 0) it.page = it.page ^ 16'hFF00;
			it.last = tail && (k == len - 1);
			send_item(it);
		end
	endtask

	// Receiver: wait a drawn number of cycles after each item, or hold off
	always @(posedge clk) begin
		int w;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_wait <= 0;
		end else if (hold_sink) begin
			out_ch.ready <= 1'b0;
		end else if (out_ch.valid && out_ch.ready) begin
			w = $urandom_range(0, 18);
			out_ch.ready <= (w == 0);
			sink_wait <= w;
		end else if (sink_wait > 0) begin
			out_ch.ready <= (sink_wait == 1);
			sink_wait <= sink_wait - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		fault_res_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("unexpected result item");
				errors++;
			end else begin
				w = pending_q.pop_front();
				if (out_ch.fault_count !== w.fault_count)
					report("fault_count", out_ch.fault_count, w.fault_count);
				if (out_ch.ref_total !== w.ref_total)
					report("ref_total", out_ch.ref_total, w.ref_total);
				if (out_ch.overflow !== w.overflow)
					report("overflow", out_ch.overflow, w.overflow);
			end
			results_seen++;
		end
	end

	// Watchdog on cycles with no handshake.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready) || long_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 50000) begin
			$display("status: fail");
			$finish;
		end
	end

	// Directed table: rows with typed expectations are checked directly too.
	dir_row_t dir_tab [] = '{
		'{16'h0000, 1'b1, 1, 7'd1, 7'd1, 1'b0},
		'{16'hFFFF, 1'b0, 0, 0, 0, 0},
		'{16'hFFFF, 1'b1, 1, 7'd1, 7'd2, 1'b0},
		'{16'h0001, 1'b0, 0, 0, 0, 0},
		'{16'h0002, 1'b0, 0, 0, 0, 0},
		'{16'h0003, 1'b0, 0, 0, 0, 0},
		'{16'h0004, 1'b0, 0, 0, 0, 0},
		'{16'h0001, 1'b0, 0, 0, 0, 0},
		'{16'h0002, 1'b0, 0, 0, 0, 0},
		'{16'h0005, 1'b0, 0, 0, 0, 0},
		'{16'h0001, 1'b0, 0, 0, 0, 0},
		'{16'h0002, 1'b0, 0, 0, 0, 0},
		'{16'h0003, 1'b0, 0, 0, 0, 0},
		'{16'h0004, 1'b0, 0, 0, 0, 0},
		'{16'h0005, 1'b1, 0, 0, 0, 0},
		'{16'hAAAA, 1'b0, 0, 0, 0, 0},
		'{16'h5555, 1'b0, 0, 0, 0, 0},
		'{16'hAAAA, 1'b1, 1, 7'd2, 7'd3, 1'b0}
	};

	task automatic run_table();
		ref_item_t it;
		fault_res_t t;
		foreach (dir_tab[r]) begin
			it.page = dir_tab[r].page;
			it.last = dir_tab[r].last;
			send_item(it);
			if (dir_tab[r].typed) begin
				t = pending_q[$];
				if (t.fault_count !== dir_tab[r].fault_count)
					report("table fault_count", t.fault_count, dir_tab[r].fault_count);
				if (t.ref_total !== dir_tab[r].ref_total)
					report("table ref_total", t.ref_total, dir_tab[r].ref_total);
				if (t.overflow !== dir_tab[r].overflow)
					report("table overflow", t.overflow, dir_tab[r].overflow);
			end
		end
	endtask

	initial begin
		logic [1:0] pol;
		in_ch.valid = 1'b0;
		in_ch.page = '0;
		in_ch.last = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		str_len = 0;
		str_dropped = 0;
		cur_policy = POL_FIFO;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset policy, then each policy and the unused code
		run_table();
		drain();
		for (int p = 1; p < 4; p++) begin
			write_policy(2'(p));
			run_table();
			drain();
		end

		// Overflow: a full store plus dropped references, last one dropped too
		write_policy(POL_OPT);
		send_string(MaxRefs + 3, 7, 1);
		send_string(MaxRefs, 5, 1);
		drain();

		// Long receiver hold-off while the sender keeps offering strings
		hold_sink = 1'b1;
		long_hold = 1'b1;
		fork
			begin
				send_string(20, 4, 1);
				send_string(10, 4, 1);
			end
			begin
				repeat (2000) @(posedge clk);
				hold_sink = 1'b0;
				long_hold = 1'b0;
			end
		join
		drain();

		// Random part: phases of policy, mostly short strings over small page sets
		while (items_sent < 1400) begin
			pol = 2'($urandom_range(0, 3));
			write_policy(pol);
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			for (int s = 0; s < 8; s++) begin
				case ($urandom_range(0, 9))
					0: send_string($urandom_range(MaxRefs - 2, MaxRefs + 4), 9, 1);
					1: send_string($urandom_range(1, 12), 0, 1);
					default: send_string($urandom_range(1, 20), $urandom_range(2, 8), 1);
				endcase
			end
			drain();
		end

		drain();
		$display("covered %0d items and %0d fault count results", items_sent, results_seen);
		$display("policies FIFO, LRU, optimal and the unused code, with overflowing strings");
		if (errors == 0 && pending_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
